// ===== hw/rtl/eacd_pkg.sv =====
`timescale 1ns / 1ps

package eacd_pkg;

  // Default sizes of the time surfaces
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int STAMP_BITS_DEF = 32;

  // Field and register widths
  localparam int STAMP_W        = 32;
  localparam int WIN_BITS       = 32;
  localparam int DIM_BITS       = 10;
  localparam int MARGIN_BITS    = 7;
  localparam int POS_BITS       = 9;
  localparam int COORD_BITS     = 12;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int RIDX_BITS      = 5;

  // Register reset values
  localparam logic [WIN_BITS-1:0]    FILTER_WINDOW_RST = 32'd50000;
  localparam logic [DIM_BITS-1:0]    ACTIVE_WIDTH_RST  = 10'd346;
  localparam logic [DIM_BITS-1:0]    ACTIVE_HEIGHT_RST = 10'd260;
  localparam logic [MARGIN_BITS-1:0] BORDER_MARGIN_RST = 7'd5;

  // Outer ring radius; the border check never uses a margin below it
  localparam logic [MARGIN_BITS-1:0] RING_RADIUS = 7'd4;

  // Ring sizes and size windows
  localparam logic [RIDX_BITS-1:0] SMALL_N   = 5'd16;
  localparam logic [RIDX_BITS-1:0] LARGE_N   = 5'd20;
  localparam logic [RIDX_BITS-1:0] SMALL_MIN = 5'd4;
  localparam logic [RIDX_BITS-1:0] SMALL_MAX = 5'd6;
  localparam logic [RIDX_BITS-1:0] LARGE_MIN = 5'd5;
  localparam logic [RIDX_BITS-1:0] LARGE_MAX = 5'd8;

  // Ring offsets, counterclockwise from straight down
  localparam logic signed [3:0] SMALL_DX [16] =
    '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam logic signed [3:0] SMALL_DY [16] =
    '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};
  localparam logic signed [3:0] LARGE_DX [20] =
    '{0, 1, 2, 3, 4, 4, 4, 3, 2, 1, 0, -1, -2, -3, -4, -4, -4, -3, -2, -1};
  localparam logic signed [3:0] LARGE_DY [20] =
    '{4, 4, 3, 2, 1, 0, -1, -2, -3, -4, -4, -4, -3, -2, -1, 0, 1, 2, 3, 4};

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FILTER_WINDOW,
    REG_ACTIVE_WIDTH,
    REG_ACTIVE_HEIGHT,
    REG_BORDER_MARGIN
  } cfg_reg_t;

  // Event request
  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [POS_BITS-1:0] col;
    logic [POS_BITS-1:0] row;
    logic                polarity;
  } in_req_t;

  // Result request
  typedef struct packed {
    logic                accepted;
    logic                corner;
    logic [POS_BITS-1:0] out_col;
    logic [POS_BITS-1:0] out_row;
  } out_rsp_t;

  // Corner test command and response
  typedef struct packed {
    logic                start;
    logic [POS_BITS-1:0] col;
    logic [POS_BITS-1:0] row;
    logic                pol;
  } arc_cmd_t;

  typedef struct packed {
    logic done;
    logic corner;
  } arc_rsp_t;

  // Ring index step with wrap
  function automatic logic [RIDX_BITS-1:0] ring_inc(input logic [RIDX_BITS-1:0] i,
                                                     input logic [RIDX_BITS-1:0] n);
    ring_inc = (i == n - 5'd1) ? '0 : i + 5'd1;
  endfunction

  function automatic logic [RIDX_BITS-1:0] ring_dec(input logic [RIDX_BITS-1:0] i,
                                                     input logic [RIDX_BITS-1:0] n);
    ring_dec = (i == '0) ? n - 5'd1 : i - 5'd1;
  endfunction

endpackage

// ===== hw/rtl/event_arc_corner_detector.sv =====
// Event corner detector: one camera event (stamp, column, row, polarity) in, one result
// (accepted, corner, echoed position) out, over valid/stall channels. The user must write
// the configuration registers through a plain write port only while the block is idle;
// the block itself does not enforce this. After reset the block clears both time
// surfaces, one address a cycle, and stalls the input meanwhile. An event outside the
// stored area goes from the read state straight to the result state, an event that is
// rejected or lies near the border passes the compare and update states first. An event
// that gets the corner test runs it on the small ring and, if that passes, on the large
// ring: the ring test runs on one comparator at one memory read per arc step, and each arc
// step passes through the branch, check, segment and minimum states. The next event is
// taken once the result has moved into the output register.
`timescale 1ns / 1ps

module event_arc_corner_detector #(
  parameter int MAX_WIDTH  = eacd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = eacd_pkg::MAX_HEIGHT_DEF,
  parameter int STAMP_BITS = eacd_pkg::STAMP_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  eacd_pkg::in_req_t                      in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output eacd_pkg::out_rsp_t                     out_data,
  input  logic                                   cfg_we,
  input  logic [eacd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [eacd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import eacd_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int SW     = (STAMP_BITS < 32) ? STAMP_BITS : 32;
  localparam int LAT_AW = CW + RW;
  localparam int FLT_AW = LAT_AW + 1;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_LRD, ST_LCMP, ST_LUPD, ST_ARC, ST_DONE
  } state_t;

  state_t               state_r;
  logic [FLT_AW-1:0]    clr_cnt_r;
  logic [SW-1:0]        stamp_r;
  logic [POS_BITS-1:0]  col_r, row_r;
  logic                 pol_r, in_range_r;
  logic                 gt_r, inv_r, border_r, acc_r, corner_r;
  logic [SW-1:0]        diff_r;
  logic                 arc_start_r;
  logic                 out_valid_r;
  out_rsp_t             out_data_r;

  logic [WIN_BITS-1:0]    win_r;
  logic [DIM_BITS-1:0]    aw_r, ah_r;
  logic [MARGIN_BITS-1:0] margin_r;

  // Surfaces: latest holds both polarities per pixel, filtered one stamp per entry
  logic [2*SW-1:0] lat_mem [2**LAT_AW];
  logic [SW-1:0]   filt_mem [2**FLT_AW];
  logic [2*SW-1:0] lat_rd_r;
  logic [SW-1:0]   filt_rd_r;

  logic [LAT_AW-1:0]  pix;
  logic [SW-1:0]      last, last_inv;
  logic               acc, border, clr;
  logic [2*SW-1:0]    lat_new;
  logic               lat_we, filt_we;
  logic [LAT_AW-1:0]  lat_wa;
  logic [FLT_AW-1:0]  filt_wa, arc_addr;
  logic [2*SW-1:0]    lat_wd;
  logic [SW-1:0]      filt_wd;
  logic [COORD_BITS-1:0] lim, w, h, col_w, row_w;
  logic               do_load;
  arc_cmd_t           arc_cmd;
  arc_rsp_t           arc_rsp;

  assign clr      = (state_r == ST_CLR);
  assign in_stall = (state_r != ST_IDLE);
  assign pix      = {RW'(row_r), CW'(col_r)};

  // Refractory filter
  assign last     = pol_r ? lat_rd_r[2*SW-1:SW] : lat_rd_r[SW-1:0];
  assign last_inv = pol_r ? lat_rd_r[SW-1:0] : lat_rd_r[2*SW-1:SW];
  assign acc      = (gt_r && (WIN_BITS'(diff_r) > win_r)) || inv_r;
  assign lat_new  = pol_r ? {stamp_r, lat_rd_r[SW-1:0]} : {lat_rd_r[2*SW-1:SW], stamp_r};

  // Border window, active size clamped to storage
  always_comb begin
    lim    = COORD_BITS'(((margin_r < RING_RADIUS) ? RING_RADIUS : margin_r)) + 12'd1;
    w      = (COORD_BITS'(aw_r) > COORD_BITS'(MAX_WIDTH)) ? COORD_BITS'(MAX_WIDTH)
                                                          : COORD_BITS'(aw_r);
    h      = (COORD_BITS'(ah_r) > COORD_BITS'(MAX_HEIGHT)) ? COORD_BITS'(MAX_HEIGHT)
                                                           : COORD_BITS'(ah_r);
    col_w  = COORD_BITS'(col_r);
    row_w  = COORD_BITS'(row_r);
    border = (col_w >= lim) && (col_w + lim < w) && (row_w >= lim) && (row_w + lim < h);
  end

  // Memory write ports
  always_comb begin
    lat_we  = clr || (state_r == ST_LUPD);
    lat_wa  = clr ? clr_cnt_r[LAT_AW-1:0] : pix;
    lat_wd  = clr ? '0 : lat_new;
    filt_we = clr || ((state_r == ST_LUPD) && acc);
    filt_wa = clr ? clr_cnt_r : {pol_r, pix};
    filt_wd = clr ? '0 : stamp_r;
  end

  always_ff @(posedge clk) begin
    if (lat_we) lat_mem[lat_wa] <= lat_wd;
    lat_rd_r <= lat_mem[pix];
  end

  always_ff @(posedge clk) begin
    if (filt_we) filt_mem[filt_wa] <= filt_wd;
    filt_rd_r <= filt_mem[arc_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= FILTER_WINDOW_RST;
      aw_r     <= ACTIVE_WIDTH_RST;
      ah_r     <= ACTIVE_HEIGHT_RST;
      margin_r <= BORDER_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILTER_WINDOW: win_r    <= cfg_data[WIN_BITS-1:0];
        REG_ACTIVE_WIDTH:  aw_r     <= cfg_data[DIM_BITS-1:0];
        REG_ACTIVE_HEIGHT: ah_r     <= cfg_data[DIM_BITS-1:0];
        REG_BORDER_MARGIN: margin_r <= cfg_data[MARGIN_BITS-1:0];
      endcase
    end
  end

  assign do_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Control sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      arc_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      arc_start_r <= 1'b0;
      if (do_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + FLT_AW'(1);
          if (clr_cnt_r == '1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            stamp_r    <= in_data.stamp[SW-1:0];
            col_r      <= in_data.col;
            row_r      <= in_data.row;
            pol_r      <= in_data.polarity;
            in_range_r <= (COORD_BITS'(in_data.col) < COORD_BITS'(MAX_WIDTH)) &&
                          (COORD_BITS'(in_data.row) < COORD_BITS'(MAX_HEIGHT));
            state_r    <= ST_LRD;
          end
        end
        ST_LRD: begin
          if (!in_range_r) begin
            acc_r    <= 1'b0;
            corner_r <= 1'b0;
            state_r  <= ST_DONE;
          end else begin
            state_r <= ST_LCMP;
          end
        end
        ST_LCMP: begin
          gt_r     <= stamp_r > last;
          diff_r   <= stamp_r - last;
          inv_r    <= last_inv > last;
          border_r <= border;
          state_r  <= ST_LUPD;
        end
        ST_LUPD: begin
          acc_r <= acc;
          if (acc && border_r) begin
            arc_start_r <= 1'b1;
            state_r     <= ST_ARC;
          end else begin
            corner_r <= 1'b0;
            state_r  <= ST_DONE;
          end
        end
        ST_ARC: begin
          if (arc_rsp.done) begin
            corner_r <= arc_rsp.corner;
            state_r  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (do_load) begin
            out_data_r.accepted <= acc_r;
            out_data_r.corner   <= corner_r;
            out_data_r.out_col  <= col_r;
            out_data_r.out_row  <= row_r;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Arc* ring test on the filtered surface
  always_comb begin
    arc_cmd.start = arc_start_r;
    arc_cmd.col   = col_r;
    arc_cmd.row   = row_r;
    arc_cmd.pol   = pol_r;
  end

  eacd_arc #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .STAMP_BITS (STAMP_BITS)
  ) u_arc (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (arc_cmd),
    .rsp     (arc_rsp),
    .rd_addr (arc_addr),
    .rd_data (filt_rd_r)
  );

endmodule

// ===== hw/rtl/eacd_arc.sv =====
`timescale 1ns / 1ps

module eacd_arc #(
  parameter int MAX_WIDTH  = eacd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = eacd_pkg::MAX_HEIGHT_DEF,
  parameter int STAMP_BITS = eacd_pkg::STAMP_BITS_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int SW = (STAMP_BITS < 32) ? STAMP_BITS : 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  eacd_pkg::arc_cmd_t   cmd,
  output eacd_pkg::arc_rsp_t   rsp,
  output logic [CW+RW:0]       rd_addr,
  input  logic [SW-1:0]        rd_data
);
  import eacd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MAX, S_MAXL, S_LRD, S_RRD, S_RWT, S_BR, S_CHK, S_SEG, S_MIN, S_END
  } arc_state_t;

  arc_state_t           state_r;
  logic                 large_r;
  logic [POS_BITS-1:0]  col_r, row_r;
  logic                 pol_r;
  logic [RIDX_BITS-1:0] idx_r, rd_idx_r, top_r, li_r, ri_r, step_r, size_r;
  logic [SW-1:0]        seg_r, lv_r, rv_r, lmin_r, rmin_r, new_r;
  logic                 side_r, ok_r, done_r, corner_r;

  logic [RIDX_BITS-1:0] n_c, min_c, max_c, ai, nidx, top_cur;
  logic signed [3:0]    dx, dy;
  logic [COORD_BITS-1:0] x, y;
  logic [SW-1:0]        cmp_a, cmp_b, curv, curmin;
  logic                 gt, checked, pass;

  // Ring constants
  always_comb begin
    n_c   = large_r ? LARGE_N   : SMALL_N;
    min_c = large_r ? LARGE_MIN : SMALL_MIN;
    max_c = large_r ? LARGE_MAX : SMALL_MAX;
  end

  assign curv   = side_r ? rv_r : lv_r;
  assign curmin = side_r ? rmin_r : lmin_r;

  // Shared comparator and its operand select
  always_comb begin
    unique case (state_r)
      S_MAX, S_MAXL: begin cmp_a = rd_data; cmp_b = seg_r;  end
      S_BR:          begin cmp_a = rv_r;    cmp_b = lv_r;   end
      S_CHK:         begin cmp_a = seg_r;   cmp_b = curv;   end
      S_SEG:         begin cmp_a = seg_r;   cmp_b = curmin; end
      S_MIN:         begin cmp_a = curmin;  cmp_b = new_r;  end
      default:       begin cmp_a = '0;      cmp_b = '0;     end
    endcase
  end
  assign gt = cmp_a > cmp_b;

  assign nidx    = gt ? ring_inc(ri_r, n_c) : ring_dec(li_r, n_c);
  assign top_cur = (rd_idx_r == '0 || gt) ? rd_idx_r : top_r;
  assign checked = step_r >= min_c;
  assign pass    = (size_r <= max_c) ||
                   ((size_r >= n_c - max_c) && (size_r <= n_c - min_c));

  // Ring point address
  always_comb begin
    unique case (state_r)
      S_MAX:   ai = idx_r;
      S_LRD:   ai = li_r;
      S_BR:    ai = nidx;
      default: ai = ri_r;
    endcase
    dx = large_r ? LARGE_DX[ai] : SMALL_DX[ai[3:0]];
    dy = large_r ? LARGE_DY[ai] : SMALL_DY[ai[3:0]];
    x  = COORD_BITS'(col_r) + {{(COORD_BITS-4){dx[3]}}, dx};
    y  = COORD_BITS'(row_r) + {{(COORD_BITS-4){dy[3]}}, dy};
  end
  assign rd_addr = {pol_r, y[RW-1:0], x[CW-1:0]};

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            col_r    <= cmd.col;
            row_r    <= cmd.row;
            pol_r    <= cmd.pol;
            large_r  <= 1'b0;
            idx_r    <= '0;
            rd_idx_r <= '0;
            state_r  <= S_MAX;
          end
        end
        // newest point on the ring, reads pipelined one per cycle
        S_MAX: begin
          if (idx_r != '0) begin
            if (rd_idx_r == '0 || gt) begin
              seg_r <= rd_data;
              top_r <= rd_idx_r;
            end
          end
          rd_idx_r <= idx_r;
          if (idx_r == n_c - 5'd1) state_r <= S_MAXL;
          else idx_r <= idx_r + 5'd1;
        end
        S_MAXL: begin
          if (rd_idx_r == '0 || gt) seg_r <= rd_data;
          top_r   <= top_cur;
          li_r    <= ring_dec(top_cur, n_c);
          ri_r    <= ring_inc(top_cur, n_c);
          state_r <= S_LRD;
        end
        S_LRD: state_r <= S_RRD;
        S_RRD: begin
          lv_r    <= rd_data;
          lmin_r  <= rd_data;
          state_r <= S_RWT;
        end
        S_RWT: begin
          rv_r    <= rd_data;
          rmin_r  <= rd_data;
          step_r  <= 5'd1;
          size_r  <= min_c;
          state_r <= S_BR;
        end
        // grow the arc on the side with the newer neighbor
        S_BR: begin
          side_r <= gt;
          if (gt) ri_r <= nidx;
          else li_r <= nidx;
          state_r <= S_CHK;
        end
        S_CHK: begin
          ok_r  <= !checked || !gt;
          if (checked && !gt) size_r <= step_r + 5'd1;
          new_r   <= rd_data;
          state_r <= S_SEG;
        end
        S_SEG: begin
          if (ok_r && gt) seg_r <= curmin;
          state_r <= S_MIN;
        end
        S_MIN: begin
          if (side_r) begin
            rv_r <= new_r;
            if (gt) rmin_r <= new_r;
          end else begin
            lv_r <= new_r;
            if (gt) lmin_r <= new_r;
          end
          if (step_r == n_c - 5'd1) state_r <= S_END;
          else begin
            step_r  <= step_r + 5'd1;
            state_r <= S_BR;
          end
        end
        // verdict; small ring pass goes on to the large ring
        S_END: begin
          if (!large_r && pass) begin
            large_r  <= 1'b1;
            idx_r    <= '0;
            rd_idx_r <= '0;
            state_r  <= S_MAX;
          end else begin
            done_r   <= 1'b1;
            corner_r <= pass && large_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.corner = corner_r;

endmodule

// ===== hw/rtl/eacd_checker.sv =====
`timescale 1ns / 1ps

module eacd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input eacd_pkg::out_rsp_t out_data
);
  import eacd_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Requests taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // One event at a time: busy right after a request is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken while previous event in work");

  // Every result belongs to a taken request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result without a pending request");

  // At most one event in work plus one result waiting
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests outstanding");

  // A corner is always an accepted event
  a_corner_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.corner || out_data.accepted))
    else $error("corner flagged on rejected event");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind event_arc_corner_detector eacd_checker u_eacd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/event_arc_corner_detector_tb.sv =====
`timescale 1ns / 1ps

module event_arc_corner_detector_tb;
  import eacd_pkg::*;

  localparam int GRID_COLS     = 512;
  localparam int GRID_ROWS     = 512;
  localparam int PLANE_DEPTH   = 2 * GRID_COLS * GRID_ROWS;
  localparam int MIN_MARGIN    = 4;
  localparam int SMALL_POINTS  = 16;
  localparam int LARGE_POINTS  = 20;
  localparam int RING_POINTS   = SMALL_POINTS + LARGE_POINTS;
  localparam int SMALL_ARC_MIN = 4;
  localparam int SMALL_ARC_MAX = 6;
  localparam int LARGE_ARC_MIN = 5;
  localparam int LARGE_ARC_MAX = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int MAX_REPORTS   = 60;

  // Directed probe: one event, plus a hand-written result where it is obvious
  typedef struct packed {
    in_req_t  ev;
    bit       typed;
    out_rsp_t want;
  } probe_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  in_req_t                   in_data;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_rsp_t                  out_data;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Ring offsets: 16-point ring of radius 3, then 20-point ring of radius 4
  int ring_dx [RING_POINTS] = '{
    0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1,
    0, 1, 2, 3, 4, 4, 4, 3, 2, 1, 0, -1, -2, -3, -4, -4, -4, -3, -2, -1};
  int ring_dy [RING_POINTS] = '{
    3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3,
    4, 4, 3, 2, 1, 0, -1, -2, -3, -4, -4, -4, -3, -2, -1, 0, 1, 2, 3, 4};

  // Time surfaces of the predictor, indexed {polarity, row, col}
  bit [31:0] latest_ts   [0:PLANE_DEPTH-1];
  bit [31:0] filtered_ts [0:PLANE_DEPTH-1];

  // Register copies
  bit [WIN_BITS-1:0]    window_ticks;
  bit [DIM_BITS-1:0]    cols_active;
  bit [DIM_BITS-1:0]    rows_active;
  bit [MARGIN_BITS-1:0] margin_px;

  out_rsp_t  pending_results [$];
  probe_t    probe_list [$];
  out_rsp_t  head_rsp;
  bit [31:0] now_tick;
  int        events_sent;
  int        fail_count;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  event_arc_corner_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Corner zone: margin floor of the ring radius, active size capped at the grid
  function automatic void corner_bounds(output int lim, output int w, output int h);
    lim = ((margin_px < MIN_MARGIN) ? MIN_MARGIN : int'(margin_px)) + 1;
    w   = (cols_active > GRID_COLS) ? GRID_COLS : int'(cols_active);
    h   = (rows_active > GRID_ROWS) ? GRID_ROWS : int'(rows_active);
  endfunction

  function automatic bit [31:0] ring_stamp(input bit pol, input int cx, input int cy,
                                           input int k);
    int x;
    int y;
    x = cx + ring_dx[k];
    y = cy + ring_dy[k];
    if (x < 0 || y < 0 || x >= GRID_COLS || y >= GRID_ROWS) return '0;
    return filtered_ts[{pol, y[8:0], x[8:0]}];
  endfunction

  // Newest-arc search on one ring, then the minority/majority size window
  function automatic bit arc_pass(input bit pol, input int cx, input int cy, input int first,
                                  input int n, input int min_th, input int max_th);
    bit [31:0] seg;
    bit [31:0] t;
    bit [31:0] lv;
    bit [31:0] rv;
    bit [31:0] lmin;
    bit [31:0] rmin;
    int        top;
    int        li;
    int        ri;
    int        size;
    int        i;
    bit        checked;
    seg = ring_stamp(pol, cx, cy, first);
    top = 0;
    for (i = 1; i < n; i++) begin
      t = ring_stamp(pol, cx, cy, first + i);
      if (t > seg) begin
        seg = t;
        top = i;
      end
    end
    li   = (top - 1 + n) % n;
    ri   = (top + 1) % n;
    lv   = ring_stamp(pol, cx, cy, first + li);
    rv   = ring_stamp(pol, cx, cy, first + ri);
    lmin = lv;
    rmin = rv;
    size = min_th;
    for (i = 1; i < n; i++) begin
      checked = (i >= min_th);
      if (rv > lv) begin
        if (!checked || rv >= seg) begin
          if (checked) size = i + 1;
          if (rmin < seg) seg = rmin;
        end
        ri = (ri + 1) % n;
        rv = ring_stamp(pol, cx, cy, first + ri);
        if (rv < rmin) rmin = rv;
      end else begin
        if (!checked || lv >= seg) begin
          if (checked) size = i + 1;
          if (lmin < seg) seg = lmin;
        end
        li = (li - 1 + n) % n;
        lv = ring_stamp(pol, cx, cy, first + li);
        if (lv < lmin) lmin = lv;
      end
    end
    return size <= max_th || (size >= n - max_th && size <= n - min_th);
  endfunction

  // Refractory filter, surface update and corner test for one event
  function automatic out_rsp_t classify_event(input in_req_t ev);
    out_rsp_t    rsp;
    logic [18:0] own_idx;
    logic [18:0] opp_idx;
    bit [31:0]   last;
    bit [31:0]   last_opp;
    int          lim;
    int          w;
    int          h;
    int          c;
    int          r;
    rsp         = '0;
    rsp.out_col = ev.col;
    rsp.out_row = ev.row;
    own_idx     = {ev.polarity, ev.row, ev.col};
    opp_idx     = {~ev.polarity, ev.row, ev.col};
    last        = latest_ts[own_idx];
    last_opp    = latest_ts[opp_idx];
    rsp.accepted = (ev.stamp > last && ev.stamp - last > window_ticks) || last_opp > last;
    latest_ts[own_idx] = ev.stamp;
    if (rsp.accepted) begin
      filtered_ts[own_idx] = ev.stamp;
      corner_bounds(lim, w, h);
      c = ev.col;
      r = ev.row;
      if (c >= lim && c < w - lim && r >= lim && r < h - lim) begin
        rsp.corner = arc_pass(ev.polarity, c, r, 0, SMALL_POINTS, SMALL_ARC_MIN,
                              SMALL_ARC_MAX) &&
                     arc_pass(ev.polarity, c, r, SMALL_POINTS, LARGE_POINTS, LARGE_ARC_MIN,
                              LARGE_ARC_MAX);
      end
    end
    return rsp;
  endfunction

  function automatic bit [31:0] next_stamp();
    now_tick += (window_ticks < 32'd2000) ? window_ticks + 32'd1 + $urandom_range(0, 30)
                                          : $urandom_range(1, 500);
    return now_tick;
  endfunction

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
      end else begin
        head_rsp = pending_results.pop_front();
        report_field("accepted", head_rsp.accepted, out_data.accepted);
        report_field("corner", head_rsp.corner, out_data.corner);
        report_field("out_col", head_rsp.out_col, out_data.out_col);
        report_field("out_row", head_rsp.out_row, out_data.out_row);
      end
    end
  end

  // Present one request, hold it until taken, then log its expected result
  task automatic send_event(input in_req_t ev, input bit typed, input out_rsp_t typed_rsp);
    out_rsp_t rsp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rsp = classify_event(ev);
    pending_results.push_back(typed ? typed_rsp : rsp);
    events_sent++;
  endtask

  task automatic send_at(input bit [31:0] st, input int c, input int r, input bit p);
    in_req_t ev;
    ev.stamp    = st;
    ev.col      = c[8:0];
    ev.row      = r[8:0];
    ev.polarity = p;
    send_event(ev, 1'b0, '0);
  endtask

  task automatic add_probe(input bit [31:0] st, input int c, input int r, input bit p,
                           input bit typed, input bit acc, input bit cor);
    probe_t pr;
    pr.ev.stamp       = st;
    pr.ev.col         = c[8:0];
    pr.ev.row         = r[8:0];
    pr.ev.polarity    = p;
    pr.typed          = typed;
    pr.want.accepted  = acc;
    pr.want.corner    = cor;
    pr.want.out_col   = c[8:0];
    pr.want.out_row   = r[8:0];
    probe_list.push_back(pr);
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input bit [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_FILTER_WINDOW: window_ticks = val[WIN_BITS-1:0];
      REG_ACTIVE_WIDTH:  cols_active  = val[DIM_BITS-1:0];
      REG_ACTIVE_HEIGHT: rows_active  = val[DIM_BITS-1:0];
      REG_BORDER_MARGIN: margin_px    = val[MARGIN_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input bit [31:0] win, input bit [31:0] w, input bit [31:0] h,
                               input bit [31:0] m);
    write_reg(REG_FILTER_WINDOW, win);
    write_reg(REG_ACTIVE_WIDTH, w);
    write_reg(REG_ACTIVE_HEIGHT, h);
    write_reg(REG_BORDER_MARGIN, m);
    cfg_we <= 1'b0;
  endtask

  // Center inside the corner zone, now and then right on its edge
  task automatic pick_center(output int c, output int r);
    int lim;
    int w;
    int h;
    corner_bounds(lim, w, h);
    c = (w - lim - 1 >= lim) ? int'($urandom_range(w - lim - 1, lim)) : $urandom_range(507, 4);
    r = (h - lim - 1 >= lim) ? int'($urandom_range(h - lim - 1, lim)) : $urandom_range(507, 4);
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1))
        c = $urandom_range(0, 1) ? lim - 1 + $urandom_range(0, 1)
                                 : w - lim - 1 + $urandom_range(0, 1);
      else
        r = $urandom_range(0, 1) ? lim - 1 + $urandom_range(0, 1)
                                 : h - lim - 1 + $urandom_range(0, 1);
    end
    c = (c < 4) ? 4 : (c > 507) ? 507 : c;
    r = (r < 4) ? 4 : (r > 507) ? 507 : r;
  endtask

  // Mostly arc patterns around a center, plus local bursts and stray events
  task automatic run_random(input int quota);
    int stop_at;
    int kind;
    int c;
    int r;
    int s;
    int k;
    int j;
    int pos;
    int pass;
    int n;
    bit p;
    stop_at = events_sent + quota;
    while (events_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) begin
        wait_for_results();
      end else if (kind < 58) begin
        // older stamps off the arc first, then the arc, then the center
        pick_center(c, r);
        s = $urandom_range(0, LARGE_POINTS - 1);
        k = $urandom_range(2, 16);
        p = $urandom_range(0, 1);
        for (pass = 0; pass < 2; pass++) begin
          for (j = 0; j < RING_POINTS; j++) begin
            pos = (j < SMALL_POINTS) ?
                  ((j * LARGE_POINTS + SMALL_POINTS / 2) / SMALL_POINTS) % LARGE_POINTS :
                  j - SMALL_POINTS;
            if (((((pos - s + LARGE_POINTS) % LARGE_POINTS) < k) == pass) &&
                $urandom_range(0, 9) != 0)
              send_at(next_stamp(), c + ring_dx[j], r + ring_dy[j], p);
          end
        end
        send_at(next_stamp(), c, r, p);
      end else if (kind < 85) begin
        // burst of mixed polarity near one spot, some stamps stepping back
        pick_center(c, r);
        n = $urandom_range(4, 16);
        for (j = 0; j < n; j++) begin
          send_at(($urandom_range(0, 4) == 0) ? now_tick - $urandom_range(0, 100) : next_stamp(),
                  c + $urandom_range(0, 8) - 4, r + $urandom_range(0, 8) - 4,
                  $urandom_range(0, 1));
        end
      end else begin
        send_at($urandom_range(0, 1) ? $urandom() : next_stamp(), $urandom_range(0, 511),
                $urandom_range(0, 511), $urandom_range(0, 1));
      end
    end
  endtask

  initial begin : stimulus
    int k;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_FILTER_WINDOW;
    cfg_data       = '0;
    window_ticks   = FILTER_WINDOW_RST;
    cols_active    = ACTIVE_WIDTH_RST;
    rows_active    = ACTIVE_HEIGHT_RST;
    margin_px      = BORDER_MARGIN_RST;
    now_tick       = 32'd200000;
    events_sent    = 0;
    fail_count     = 0;
    send_idle_pct  = 21;
    recv_stall_pct = 65;

    // Directed probes at the reset settings (window 50000, 346 x 260, margin 5)
    add_probe(32'd0, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);              // stamp not above zero
    add_probe(32'd50000, 1, 1, 1'b1, 1'b1, 1'b0, 1'b0);          // exactly the window
    add_probe(32'd50001, 2, 2, 1'b1, 1'b1, 1'b1, 1'b0);          // passes, on the border
    add_probe(32'hFFFF_FFFF, 511, 511, 1'b0, 1'b1, 1'b1, 1'b0);  // top stamp, far corner
    add_probe(32'd0, 511, 511, 1'b0, 1'b1, 1'b0, 1'b0);          // stamp below stored time
    add_probe(32'd5, 511, 511, 1'b1, 1'b1, 1'b0, 1'b0);          // opposite not newer
    add_probe(32'd6, 511, 511, 1'b1, 1'b1, 1'b0, 1'b0);          // inside the window
    add_probe(32'd100000, 511, 511, 1'b0, 1'b1, 1'b1, 1'b0);
    add_probe(32'd60000, 5, 100, 1'b1, 1'b1, 1'b1, 1'b0);        // one short of the corner zone
    add_probe(32'd60000, 340, 100, 1'b1, 1'b1, 1'b1, 1'b0);      // right border
    add_probe(32'd60000, 100, 254, 1'b0, 1'b1, 1'b1, 1'b0);      // bottom border
    add_probe(32'd60000, 400, 100, 1'b0, 1'b1, 1'b1, 1'b0);      // outside active area
    add_probe(32'd60000, 6, 6, 1'b0, 1'b0, 1'b0, 1'b0);          // first corner-zone pixel
    add_probe(32'd60000, 339, 253, 1'b1, 1'b0, 1'b0, 1'b0);      // last corner-zone pixel
    // one quadrant of both rings newer than the rest, then its center
    add_probe(32'd70000, 201, 154, 1'b1, 1'b0, 1'b0, 1'b0);
    add_probe(32'd70001, 202, 153, 1'b1, 1'b0, 1'b0, 1'b0);
    add_probe(32'd70002, 203, 152, 1'b1, 1'b0, 1'b0, 1'b0);
    add_probe(32'd70003, 204, 151, 1'b1, 1'b0, 1'b0, 1'b0);
    add_probe(32'd70004, 201, 153, 1'b1, 1'b0, 1'b0, 1'b0);
    add_probe(32'd70005, 202, 152, 1'b1, 1'b0, 1'b0, 1'b0);
    add_probe(32'd70006, 203, 151, 1'b1, 1'b0, 1'b0, 1'b0);
    add_probe(32'd70010, 200, 150, 1'b1, 1'b0, 1'b0, 1'b0);
    add_probe(32'd70011, 200, 150, 1'b1, 1'b1, 1'b0, 1'b0);      // one tick later: rejected

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < probe_list.size(); k++)
      send_event(probe_list[k].ev, probe_list[k].typed, probe_list[k].want);
    wait_for_results();

    // Setting sweep: window, width, height, margin
    apply_setting(32'd0, 32'd512, 32'd512, 32'd4);
    run_random(250);
    wait_for_results();
    apply_setting(32'd100, 32'd1023, 32'd1023, 32'd0);
    run_random(250);
    wait_for_results();

    send_idle_pct  = 65;
    recv_stall_pct = 21;
    apply_setting(32'hFFFF_FFFF, 32'd16, 32'd16, 32'd127);
    run_random(120);
    wait_for_results();
    apply_setting(32'd50, 32'hFFFF_FD5A, 32'd260, 32'd64);
    run_random(220);
    wait_for_results();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_setting(32'd1000, 32'd200, 32'd300, 32'd10);
    run_random(220);
    wait_for_results();
    apply_setting(32'd7, 32'd346, 32'd260, 32'd5);
    run_random(240);
    wait_for_results();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit, covering the surface clear after reset
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
